// File: design/sha_pkg.sv
// Package for the streaming SHA-256 hasher: payload types, queue entry type,
// round constants, initial hash values and a rotate-right helper function.
package sha_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic KindByte   = 1'b0;
  localparam logic KindFinish = 1'b1;

  typedef enum logic [1:0] {
    JOB_DATA,
    JOB_PAD,
    JOB_FINAL
  } job_e;

  typedef struct packed {
    job_e         job;
    logic [511:0] block;
  } job_t;

  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_ROUND,
    BE_ADD,
    BE_EMIT
  } be_state_e;

  typedef logic [7:0][31:0] hash_t;

  localparam hash_t HInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

  localparam logic [63:0][31:0] RoundK = {
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98};

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// File: design/sha_front.sv
// Front end: collects message bytes into 64-byte blocks, builds padded blocks on
// finish and pushes compression jobs into the job queue. Uses sha_pkg.
module sha_front import sha_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t in_i,
  output logic     full_o,
  output logic     job_valid_o,
  output job_t     job_o,
  input  logic     job_ready_i
);

  logic [63:0][7:0] buf_q, buf_d;
  logic [5:0]       fill_q, fill_d;
  logic [63:0]      bits_q, bits_d;
  logic             pend_q, pend_d;
  job_t             job_q, job_d;
  logic             two_q, two_d;
  job_t             job2_q, job2_d;

  logic [511:0] flat;
  logic [63:0]  total;
  logic [63:0][7:0] padded;

  assign full_o      = pend_q;
  assign job_valid_o = pend_q;
  assign job_o       = job_q;

  always_comb begin
    flat = '0;
    for (int i = 0; i < 64; i++) begin
      flat[511 - 8*i -: 8] = buf_q[i];
    end
    total = bits_q + {55'd0, fill_q, 3'd0};
    padded = buf_q;
    for (int i = 0; i < 64; i++) begin
      if (6'(i) == fill_q) padded[i] = PadByte;
      else if (6'(i) > fill_q) padded[i] = 8'h00;
    end
  end

  always_comb begin
    logic [511:0] pflat;
    logic [511:0] zblk;
    pflat  = '0;
    buf_d  = buf_q;
    fill_d = fill_q;
    bits_d = bits_q;
    pend_d = pend_q;
    job_d  = job_q;
    two_d  = two_q;
    job2_d = job2_q;
    for (int i = 0; i < 64; i++) begin
      pflat[511 - 8*i -: 8] = padded[i];
    end
    zblk = {448'd0, total};
    if (pend_q && job_ready_i) begin
      if (two_q) begin
        job_d = job2_q;
        two_d = 1'b0;
      end else begin
        pend_d = 1'b0;
      end
    end
    if (push_i && !pend_q) begin
      if (in_i.kind == KindByte) begin
        buf_d[fill_q] = in_i.data_byte;
        fill_d = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          job_d.job        = JOB_DATA;
          job_d.block      = {flat[511:8], in_i.data_byte};
          bits_d = bits_q + 64'd512;
          pend_d = 1'b1;
        end
      end else begin
        pend_d = 1'b1;
        fill_d = '0;
        bits_d = '0;
        if (fill_q >= 6'd56) begin
          job_d.job        = JOB_PAD;
          job_d.block      = pflat;
          two_d            = 1'b1;
          job2_d.job        = JOB_FINAL;
          job2_d.block      = zblk;
        end else begin
          job_d.job        = JOB_FINAL;
          job_d.block      = {pflat[511:64], total};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bits_q <= '0;
      pend_q <= 1'b0;
      two_q  <= 1'b0;
    end else begin
      fill_q <= fill_d;
      bits_q <= bits_d;
      pend_q <= pend_d;
      two_q  <= two_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    job_q  <= job_d;
    job2_q <= job2_d;
  end

endmodule

// File: design/sha_job_queue.sv
// Two-entry job queue between the front end and the compression engine.
// Uses sha_pkg for the job type and depth.
module sha_job_queue import sha_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  input  job_t wr_i,
  output logic wr_ready_o,
  output logic rd_valid_o,
  output job_t rd_o,
  input  logic rd_ready_i
);

  job_t       mem_q [QDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'(QDepth));
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_o       = mem_q[rp_q];
  assign wr         = wr_valid_i && wr_ready_o;
  assign rd         = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_i;
  end

endmodule

// File: design/sha_engine.sv
// Back end: one SHA-256 round per cycle with a rolling 16-word schedule,
// running hash update and digest emission. Uses sha_pkg.
module sha_engine import sha_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      job_ready_o,
  output logic      empty_o,
  output out_item_t out_o,
  input  logic      pop_i
);

  be_state_e        state_q, state_d;
  hash_t            h_q, h_d;
  logic [7:0][31:0] v_q, v_d;
  logic [15:0][31:0] w_q, w_d;
  logic [5:0]       rnd_q, rnd_d;
  logic             fin_q, fin_d;
  logic [2:0]       idx_q, idx_d;

  logic [31:0] t1, t2, s0, s1, wn, e, a;

  always_comb begin
    e  = v_q[4];
    a  = v_q[0];
    t1 = v_q[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & v_q[5]) ^ (~e & v_q[6]))
         + RoundK[rnd_q] + w_q[0];
    t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) ^ 32'd0;
    t2 = t2 + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
    s0 = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
    wn = s1 + w_q[9] + s0 + w_q[0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BE_IDLE:  if (job_valid_i) state_d = BE_ROUND;
      BE_ROUND: if (rnd_q == 6'd63) state_d = BE_ADD;
      BE_ADD:   state_d = fin_q ? BE_EMIT : BE_IDLE;
      BE_EMIT:  if (pop_i && idx_q == 3'd7) state_d = BE_IDLE;
      default:  state_d = BE_IDLE;
    endcase
  end

  always_comb begin
    h_d   = h_q;
    v_d   = v_q;
    w_d   = w_q;
    rnd_d = rnd_q;
    fin_d = fin_q;
    idx_d = idx_q;
    job_ready_o = 1'b0;
    case (state_q)
      BE_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          v_d   = h_q;
          rnd_d = '0;
          fin_d = (job_i.job == JOB_FINAL);
          for (int i = 0; i < 16; i++) w_d[i] = job_i.block[511 - 32*i -: 32];
        end
      end
      BE_ROUND: begin
        v_d = {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
        w_d = {wn, w_q[15:1]};
        rnd_d = rnd_q + 6'd1;
      end
      BE_ADD: begin
        for (int i = 0; i < 8; i++) h_d[i] = h_q[i] + v_q[i];
        idx_d = '0;
      end
      BE_EMIT: begin
        if (pop_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) h_d = HInit;
        end
      end
      default: ;
    endcase
  end

  assign empty_o           = (state_q != BE_EMIT);
  assign out_o.digest_word = h_q[idx_q];
  assign out_o.word_index  = idx_q;
  assign out_o.last_word   = (idx_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BE_IDLE;
      h_q     <= HInit;
      rnd_q   <= '0;
      fin_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      h_q     <= h_d;
      rnd_q   <= rnd_d;
      fin_q   <= fin_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    w_q <= w_d;
  end

endmodule

// File: design/sha256_stream_hasher_core.sv
// Top level of the streaming SHA-256 hasher: front end, job queue and engine.
// Uses sha_pkg, sha_front, sha_job_queue and sha_engine.
//
// Input channel: push / full, payload in_i (kind, data_byte). A byte item
// is stored in the block buffer; the 64th byte of a block hands a full block
// to a two-entry job queue. A finish item hands one padded block, or two
// when 56 or more bytes are pending, and restarts the byte count.
// Each compression in the engine is a load, 64 rounds at one per cycle and
// one hash add, so a long message's throughput is set by the round loop;
// full rises for one cycle per block handoff and stays high while a handed-off
// block waits on a full queue.
// Result channel: empty / pop, payload out_o (digest_word, word_index,
// last_word). The eight digest words appear after the rounds and hash add of the
// last job in the engine, one per pop. While the receiver stalls, the engine
// holds; the front end keeps taking bytes until the queue is full and a block waits.
// Reset: asynchronous, active low; hash words return to the initial values,
// counts and queues clear. No clearing pass is needed.
module sha256_stream_hasher_core import sha_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  input  in_item_t  in_i,
  output logic      full,
  output logic      empty,
  output out_item_t out_o,
  input  logic      pop
);

  logic fq_valid, fq_ready, qe_valid, qe_ready;
  job_t fq_job, qe_job;

  sha_front u_front (
    .clk_i, .rst_ni, .push_i(push), .in_i, .full_o(full),
    .job_valid_o(fq_valid), .job_o(fq_job), .job_ready_i(fq_ready)
  );

  sha_job_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fq_valid), .wr_i(fq_job), .wr_ready_o(fq_ready),
    .rd_valid_o(qe_valid), .rd_o(qe_job), .rd_ready_i(qe_ready)
  );

  sha_engine u_engine (
    .clk_i, .rst_ni, .job_valid_i(qe_valid), .job_i(qe_job), .job_ready_o(qe_ready),
    .empty_o(empty), .out_o, .pop_i(pop)
  );

endmodule

// File: design/sha_checker.sv
// Port checker for the hasher top level, attached by bind.
// Uses sha_pkg for the result type.
module sha_checker import sha_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input out_item_t out_o
);

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_o.last_word == (out_o.word_index == 3'd7)))
    else $error("last_word does not match word_index");

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !out_o.last_word) |=> (!empty && out_o.word_index == $past(out_o.word_index) + 3'd1))
    else $error("digest words not consecutive");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_o)))
    else $error("stalled result changed");

  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && out_o.last_word) |=> empty)
    else $error("result after last word");

endmodule

bind sha256_stream_hasher_core sha_checker u_sha_checker (
  .clk_i, .rst_ni, .empty, .pop, .out_o
);

// File: sim/tb_sha256_stream_hasher_core.sv
// Testbench for sha256_stream_hasher_core: directed table of message bytes and
// finish markers, then random messages, checked against a SHA-256 predictor.
// Depends on sha_pkg for payload types and kind codes.
`timescale 1ns / 100ps

module tb_sha256_stream_hasher_core;
  import sha_pkg::*;

  localparam int unsigned IdleMax   = 11;
  localparam int unsigned StallMax  = 11;
  localparam int unsigned WatchMax  = 20000;
  localparam int unsigned DrainWait = 200;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  in_item_t  in_i;
  logic      full;
  logic      empty;
  out_item_t out_o;
  logic      pop;

  sha256_stream_hasher_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .in_i  (in_i),
    .full  (full),
    .empty (empty),
    .out_o (out_o),
    .pop   (pop)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  localparam logic [63:0][31:0] RoundConst = {
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98};
  localparam logic [7:0][31:0] StartHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

  logic [7:0][31:0] run_hash;
  logic [7:0]       blk [64];
  int unsigned      blk_fill;
  logic [63:0]      msg_bits;

  out_item_t   digest_q[$];
  int unsigned mismatches;
  int unsigned digests_seen;
  int unsigned bytes_sent;
  int unsigned idle_cycles;

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    {h, g, f, e, d, c, b, a} = run_hash;
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + RoundConst[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    run_hash[0] += a; run_hash[1] += b; run_hash[2] += c; run_hash[3] += d;
    run_hash[4] += e; run_hash[5] += f; run_hash[6] += g; run_hash[7] += h;
  endtask

  task automatic hasher_clear();
    run_hash = StartHash;
    blk_fill = 0;
    msg_bits = '0;
  endtask

  task automatic predict_digest(in_item_t it);
    logic [63:0] total;
    out_item_t   o;
    if (it.kind == KindByte) begin
      blk[blk_fill] = it.data_byte;
      blk_fill++;
      if (blk_fill == 64) begin
        compress_block();
        msg_bits += 64'd512;
        blk_fill = 0;
      end
      return;
    end
    total = msg_bits + 64'(blk_fill * 8);
    blk[blk_fill] = PadByte;
    for (int i = blk_fill + 1; i < 64; i++) blk[i] = 8'h00;
    if (blk_fill >= 56) begin
      compress_block();
      for (int i = 0; i < 56; i++) blk[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) blk[56+i] = total[63-8*i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      o.digest_word = run_hash[i];
      o.word_index  = 3'(i);
      o.last_word   = (i == 7);
      digest_q = {digest_q, o};
    end
    hasher_clear();
  endtask

  // Directed table: runs of bytes (count, value, step) or a finish marker.
  typedef struct {
    logic        kind;
    int unsigned count;
    logic [7:0]  value;
    logic [7:0]  step;
    logic [31:0] word0;
  } row_t;

  localparam int unsigned NumRows = 6;
  row_t rows [NumRows] = '{
    '{KindFinish,   1, 8'hff, 8'h00, 32'he3b0c442},
    '{KindByte,     1, 8'h61, 8'h01, 32'h0},
    '{KindByte,     2, 8'h62, 8'h01, 32'h0},
    '{KindFinish,   1, 8'h00, 8'h00, 32'hba7816bf},
    '{KindByte,   120, 8'h00, 8'hff, 32'h0},
    '{KindFinish,   1, 8'h5a, 8'h00, 32'h0}
  };

  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IdleMax);
    if (gap != 0) begin
      push <= 1'b0;
      in_i <= in_item_t'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (full);
    predict_digest(it);
    if (it.kind == KindByte) bytes_sent++;
  endtask

  always @(posedge clk_i) begin
    if (push && !full || pop && !empty) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchMax) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("sha256_stream_hasher_core regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest word %h", out_o);
      end else begin
        want = digest_q.pop_front();
        if (out_o.digest_word !== want.digest_word || out_o.word_index !== want.word_index
            || out_o.last_word !== want.last_word) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: want %h/%0d/%0b got %h/%0d/%0b",
                     want.digest_word, want.word_index, want.last_word,
                     out_o.digest_word, out_o.word_index, out_o.last_word);
        end
        if (want.last_word) digests_seen++;
      end
    end
  end

  initial begin
    int unsigned stall;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, StallMax);
        if (stall != 0) begin
          pop <= 1'b0;
          repeat (stall) @(posedge clk_i);
          pop <= 1'b1;
        end
      end else if (!pop) begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    in_item_t    it;
    logic [31:0] first_want;
    int unsigned len;
    rst_ni      = 1'b0;
    push        = 1'b0;
    in_i        = '0;
    mismatches  = 0;
    digests_seen = 0;
    bytes_sent  = 0;
    idle_cycles = 0;
    hasher_clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) begin
      for (int k = 0; k < rows[r].count; k++) begin
        it.kind      = rows[r].kind;
        it.data_byte = rows[r].value + 8'(k) * rows[r].step;
        if (it.kind == KindFinish && rows[r].word0 != 0) begin
          send_item(it);
          first_want = digest_q[digest_q.size()-8].digest_word;
          if (first_want !== rows[r].word0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("predictor word 0 %h, table %h", first_want, rows[r].word0);
          end
        end else begin
          send_item(it);
        end
      end
    end

    // Hold until the directed digests have all drained.
    push <= 1'b0;
    wait (digest_q.size() == 0);

    for (int m = 0; m < 2; m++) begin
      len = $urandom_range(0, 6);
      for (int k = 0; k < len; k++) begin
        it = in_item_t'($urandom);
        it.kind = KindByte;
        send_item(it);
      end
      it = in_item_t'($urandom);
      it.kind = KindFinish;
      send_item(it);
    end

    push <= 1'b0;
    wait (digest_q.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    $display("covered %0d message bytes and %0d digests, including empty and two-block tails",
             bytes_sent, digests_seen);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("sha256_stream_hasher_core regression: pass");
    end else begin
      $display("sha256_stream_hasher_core regression: fail");
    end
    $finish;
  end

endmodule
